/* src/uasmd_pkg.sv */
// Shared types and constants for the unsigned add/sub/mul/div core.
`timescale 1ns / 1ps
`default_nettype none

package uasmd_pkg;

  localparam int DATA_WIDTH_DEF = 64;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic  load;
    logic  mul_step;
    logic  div_step;
    logic  finish;
    mode_t op;
  } cmd_t;

endpackage

`default_nettype wire

/* src/uasmd_ctrl.sv */
// Controller state machine: sequences load, iteration steps and result capture.
`timescale 1ns / 1ps
`default_nettype none

module uasmd_ctrl #(
  parameter int DATA_WIDTH = uasmd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      mode,
  output logic                 busy,
  output logic                 done,
  output uasmd_pkg::cmd_t      cmd
);

  localparam int CntW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  uasmd_pkg::state_t state, state_next;
  uasmd_pkg::mode_t  op, op_next;
  uasmd_pkg::mode_t  mode_in;
  logic [CntW-1:0]   count, count_next;
  logic              done_next;

  assign mode_in = uasmd_pkg::mode_t'(mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uasmd_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    op    <= op_next;
    count <= count_next;
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    count_next = count;
    done_next  = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    busy       = (state != uasmd_pkg::ST_IDLE);
    case (state)
      uasmd_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          op_next    = mode_in;
          count_next = CntW'(DATA_WIDTH - 1);
          if (mode_in inside {uasmd_pkg::MODE_ADD, uasmd_pkg::MODE_SUB}) begin
            state_next = uasmd_pkg::ST_FIN;
          end else begin
            state_next = uasmd_pkg::ST_ITER;
          end
        end
      end
      uasmd_pkg::ST_ITER: begin
        cmd.mul_step = (op == uasmd_pkg::MODE_MUL);
        cmd.div_step = (op == uasmd_pkg::MODE_DIV);
        count_next   = count - 1'b1;
        if (count == '0) begin
          state_next = uasmd_pkg::ST_FIN;
        end
      end
      uasmd_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        done_next  = 1'b1;
        state_next = uasmd_pkg::ST_IDLE;
      end
      default: begin
        state_next = uasmd_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == uasmd_pkg::ST_FIN))
    else $error("done without a finish cycle");

  a_no_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != uasmd_pkg::ST_IDLE) |-> !done)
    else $error("done while a beat is still in work");

  a_addsub_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode_in == uasmd_pkg::MODE_ADD || mode_in == uasmd_pkg::MODE_SUB))
      |=> ##1 done)
    else $error("add/sub result not delivered after two cycles");

  a_iter_holds: assert property (@(posedge clk) disable iff (rst)
    (state == uasmd_pkg::ST_ITER && count != '0) |=> (state == uasmd_pkg::ST_ITER))
    else $error("iteration ended early");
`endif

endmodule

`default_nettype wire

/* src/uasmd_dpath.sv */
// Datapath: operand registers, shift-add multiplier and restoring divider steps.
`timescale 1ns / 1ps
`default_nettype none

module uasmd_dpath #(
  parameter int DATA_WIDTH = uasmd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire uasmd_pkg::cmd_t       cmd,
  input  wire logic [DATA_WIDTH-1:0] operand_a,
  input  wire logic [DATA_WIDTH-1:0] operand_b,
  output logic      [DATA_WIDTH-1:0] result
);

  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] res_sel;

  // Restoring division step: acc holds the partial remainder, a shifts in quotient bits.
  always_comb begin
    shifted  = {acc, a[DATA_WIDTH-1]};
    ge       = (shifted >= {1'b0, b});
    diff     = shifted - {1'b0, b};
    rem_next = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
  end

  always_comb begin
    case (cmd.op)
      uasmd_pkg::MODE_ADD: res_sel = a + b;
      uasmd_pkg::MODE_SUB: res_sel = a - b;
      uasmd_pkg::MODE_MUL: res_sel = acc;
      uasmd_pkg::MODE_DIV: res_sel = (b == '0) ? '0 : a;
      default:             res_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= operand_a;
      b   <= operand_b;
      acc <= '0;
    end
    if (cmd.mul_step) begin
      if (b[0]) begin
        acc <= acc + a;
      end
      a <= a << 1;
      b <= b >> 1;
    end
    if (cmd.div_step) begin
      acc <= rem_next;
      a   <= {a[DATA_WIDTH-2:0], ge};
    end
    if (cmd.finish) begin
      result <= res_sel;
    end
  end

endmodule

`default_nettype wire

/* src/unsigned_64bit_add_sub_mul_div_core.sv */
// Top level of the unsigned add/sub/mul/div core.
// Add and subtract go from idle straight to the finish state, which registers
// the result together with done; multiply and divide first iterate in ST_ITER,
// one bit per cycle through the shift-add multiplier or the restoring divider loop.
// A new beat may be started in the cycle done is high. rst (synchronous) returns
// the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_64bit_add_sub_mul_div_core #(
  parameter int DATA_WIDTH = uasmd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            mode,
  input  wire logic [DATA_WIDTH-1:0] operand_a,
  input  wire logic [DATA_WIDTH-1:0] operand_b,
  output logic                       done,
  output logic      [DATA_WIDTH-1:0] result
);

  uasmd_pkg::cmd_t cmd;

  uasmd_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  uasmd_dpath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .result    (result)
  );

endmodule

`default_nettype wire

/* tb/unsigned_64bit_add_sub_mul_div_core_test.sv */
// Self-checking testbench for the unsigned 64-bit add/sub/mul/div core.
`timescale 1ns / 1ps

module unsigned_64bit_add_sub_mul_div_core_test;

  localparam int W = 64;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = W + 6;

  typedef struct {
    uasmd_pkg::mode_t op;
    logic [W-1:0]     a;
    logic [W-1:0]     b;
    logic [W-1:0]     value;
  } alu_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic [1:0]   mode = uasmd_pkg::MODE_ADD;
  logic [W-1:0] operand_a = '0;
  logic [W-1:0] operand_b = '0;
  logic         busy;
  logic         done;
  logic [W-1:0] result;

  alu_beat_t pending_results[$];
  int        mismatches = 0;
  int        beats_sent = 0;
  int        results_seen = 0;
  int        op_count[4];
  int        zero_divisors = 0;
  int        quiet_cycles = 0;
  bit        gaps_on = 1'b1;

  unsigned_64bit_add_sub_mul_div_core #(
    .DATA_WIDTH(W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .done(done),
    .result(result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [W-1:0] alu_predict(uasmd_pkg::mode_t op, logic [W-1:0] a,
                                                logic [W-1:0] b);
    logic [W-1:0] r;
    case (op)
      uasmd_pkg::MODE_ADD: r = a + b;
      uasmd_pkg::MODE_SUB: r = a - b;
      uasmd_pkg::MODE_MUL: r = a * b;
      default:             r = (b == '0) ? '0 : a / b;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // result check, expectation capture and stall watchdog in one process
  always @(posedge clk) begin : monitor
    alu_beat_t expected;
    alu_beat_t taken;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h with no beat outstanding", result));
        end else begin
          expected = pending_results.pop_front();
          if (result !== expected.value)
            report_mismatch($sformatf("%s a=%h b=%h: got %h, expected %h",
                                      expected.op.name(), expected.a, expected.b,
                                      result, expected.value));
        end
      end
      if (start && !busy) begin
        taken.op = uasmd_pkg::mode_t'(mode);
        taken.a = operand_a;
        taken.b = operand_b;
        taken.value = alu_predict(taken.op, operand_a, operand_b);
        pending_results.push_back(taken);
        beats_sent++;
        op_count[mode]++;
        if (taken.op == uasmd_pkg::MODE_DIV && operand_b == '0) zero_divisors++;
      end
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("stalled: no beat and no result for %0d cycles", STALL_LIMIT);
        $display("unsigned_64bit_add_sub_mul_div_core test failed");
        $finish;
      end
    end
  end

  // call right after a rising edge; returns at the accepting edge or after a gap
  task automatic send_beat(input uasmd_pkg::mode_t op, input logic [W-1:0] a,
                           input logic [W-1:0] b);
    start <= 1'b1;
    mode <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = ALL_ONES;
      2: begin
        v = '0;
        v[$urandom_range(0, W-1)] = 1'b1;
      end
      3: v = v >> $urandom_range(1, W-1);
      4: v = $urandom_range(0, 15);
      5: v = ALL_ONES - $urandom_range(0, 15);
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_beat(uasmd_pkg::MODE_ADD, '0, '0);
    send_beat(uasmd_pkg::MODE_ADD, ALL_ONES, 64'd1);
    send_beat(uasmd_pkg::MODE_ADD, ALL_ONES, ALL_ONES);
    send_beat(uasmd_pkg::MODE_ADD, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_beat(uasmd_pkg::MODE_SUB, '0, 64'd1);
    send_beat(uasmd_pkg::MODE_SUB, ALL_ONES, ALL_ONES);
    send_beat(uasmd_pkg::MODE_SUB, 64'd5, 64'd7);
    send_beat(uasmd_pkg::MODE_SUB, ALL_ONES, '0);
    send_beat(uasmd_pkg::MODE_MUL, ALL_ONES, ALL_ONES);
    send_beat(uasmd_pkg::MODE_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
    send_beat(uasmd_pkg::MODE_MUL, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
    send_beat(uasmd_pkg::MODE_MUL, '0, ALL_ONES);
    send_beat(uasmd_pkg::MODE_MUL, 64'h8000_0000, 64'h1_0000_0001);
    send_beat(uasmd_pkg::MODE_DIV, ALL_ONES, '0);
    send_beat(uasmd_pkg::MODE_DIV, '0, '0);
    send_beat(uasmd_pkg::MODE_DIV, ALL_ONES, 64'd1);
    send_beat(uasmd_pkg::MODE_DIV, 64'd7, ALL_ONES);
    send_beat(uasmd_pkg::MODE_DIV, ALL_ONES, ALL_ONES);
    send_beat(uasmd_pkg::MODE_DIV, 64'd100, 64'd7);
    send_beat(uasmd_pkg::MODE_DIV, 64'h8000_0000_0000_0000, 64'd3);
    send_beat(uasmd_pkg::MODE_DIV, ALL_ONES, 64'h8000_0000_0000_0000);
    send_beat(uasmd_pkg::MODE_DIV, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF);
  endtask

  // sender holds off until the core has returned every outstanding beat
  task automatic test_pause_until_empty();
    repeat (5) begin
      repeat ($urandom_range(1, 5)) send_beat(uasmd_pkg::mode_t'($urandom_range(0, 3)),
                                              pick_operand(), pick_operand());
      wait_for_results();
    end
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_beat(uasmd_pkg::mode_t'($urandom_range(0, 3)),
                             pick_operand(), pick_operand());
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    repeat (count) send_beat(uasmd_pkg::mode_t'($urandom_range(0, 3)),
                             pick_operand(), pick_operand());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_for_results();
    test_pause_until_empty();
    test_random_mix(700);
    wait_for_results();
    test_back_to_back(300);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d beats: %0d add, %0d sub, %0d mul, %0d div (%0d by zero).",
             beats_sent, op_count[uasmd_pkg::MODE_ADD], op_count[uasmd_pkg::MODE_SUB],
             op_count[uasmd_pkg::MODE_MUL], op_count[uasmd_pkg::MODE_DIV], zero_divisors);
    $display("Checked %0d results with and without sender gaps; %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("unsigned_64bit_add_sub_mul_div_core test passed");
    end else begin
      $display("unsigned_64bit_add_sub_mul_div_core test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/uasmd_pkg.sv
src/uasmd_ctrl.sv
src/uasmd_dpath.sv
src/unsigned_64bit_add_sub_mul_div_core.sv
tb/unsigned_64bit_add_sub_mul_div_core_test.sv
